FILE: hdl/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg: shared types and constants for the Smith/Beckmann lambda pipeline
// Fixed-point formats, rational approximation coefficients and the
// transaction payload structs.
// ----------------------------------------------------------------------------
package sbl_pkg;

    // Component width of the normal and direction, signed Q1.(W-2)
    localparam int SBL_COMP_W = 16;
    localparam int SBL_ROUGH_W = 16;
    localparam int SBL_LAMBDA_W = 32;

    // Roughness floor (about 0.001 in Q2.14)
    localparam logic [SBL_ROUGH_W-1:0] SBL_MIN_ROUGH = 16'd17;

    // Rational approximation coefficients, Q.16 rounded to nearest
    localparam logic [16:0] SBL_K_LIN   = 17'd82510;   // 1.259
    localparam logic [14:0] SBL_K_QUAD  = 15'd25952;   // 0.396
    localparam logic [17:0] SBL_K_DLIN  = 18'd231670;  // 3.535
    localparam logic [17:0] SBL_K_DQUAD = 18'd142934;  // 2.181

    typedef struct packed {
        logic signed [SBL_COMP_W-1:0] normal_x;
        logic signed [SBL_COMP_W-1:0] normal_y;
        logic signed [SBL_COMP_W-1:0] normal_z;
        logic signed [SBL_COMP_W-1:0] dir_x;
        logic signed [SBL_COMP_W-1:0] dir_y;
        logic signed [SBL_COMP_W-1:0] dir_z;
        logic        [SBL_ROUGH_W-1:0] roughness;
    } sbl_item_t;

    typedef struct packed {
        logic [SBL_LAMBDA_W-1:0] lambda_value;
        logic                    saturated;
    } sbl_result_t;

    // Result selection flags carried alongside the final divide
    typedef struct packed {
        logic force_max;
        logic force_zero;
    } sbl_sel_t;

endpackage

FILE: hdl/sbl_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// sbl_sqrt_pipe: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage, with a
// sideband word and a valid bit traveling alongside.
// ----------------------------------------------------------------------------
module sbl_sqrt_pipe #(
    parameter int NR = 29,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*NR-1:0] x_in,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [NR-1:0]   root,
    output logic [SW-1:0]   side_out
);

    localparam int RW = NR + 2;

    logic [RW-1:0]   rem_reg   [NR];
    logic [NR-1:0]   root_reg  [NR];
    logic [2*NR-1:0] x_reg     [NR];
    logic [SW-1:0]   side_reg  [NR];
    logic            valid_reg [NR];

    genvar i;
    for (i = 0; i < NR; i++)
    begin : g_step
        logic [RW-1:0]   src_rem;
        logic [NR-1:0]   src_root;
        logic [2*NR-1:0] src_x;
        logic [SW-1:0]   src_side;
        logic            src_valid;
        logic [RW+1:0]   r4;
        logic [RW+1:0]   trial;
        logic            ge;

        if (i == 0)
        begin : g_first
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_x     = x_in;
            assign src_side  = side_in;
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src_rem   = rem_reg[i-1];
            assign src_root  = root_reg[i-1];
            assign src_x     = x_reg[i-1];
            assign src_side  = side_reg[i-1];
            assign src_valid = valid_reg[i-1];
        end

        // bring down the next bit pair and try root*4+1
        assign r4    = {src_rem, src_x[2*NR-1:2*NR-2]};
        assign trial = {2'b00, src_root, 2'b01};
        assign ge    = (r4 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? RW'(r4 - trial) : r4[RW-1:0];
                root_reg[i] <= {src_root[NR-2:0], ge};
                x_reg[i]    <= {src_x[2*NR-3:0], 2'b00};
                side_reg[i] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[NR-1];
    assign root      = root_reg[NR-1];
    assign side_out  = side_reg[NR-1];

endmodule

FILE: hdl/sbl_div_pipe.sv
// ----------------------------------------------------------------------------
// sbl_div_pipe: pipelined restoring divider
// Produces QW quotient bits, one per register stage. The caller supplies the
// upper dividend part as the starting remainder (below the divisor) and the
// lower QW dividend bits.
// ----------------------------------------------------------------------------
module sbl_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [DW-1:0] dvs_in,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] low_reg   [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [DW-1:0] dvs_reg   [QW];
    logic [SW-1:0] side_reg  [QW];
    logic          valid_reg [QW];

    genvar i;
    for (i = 0; i < QW; i++)
    begin : g_step
        logic [DW-1:0] src_rem;
        logic [QW-1:0] src_low;
        logic [QW-1:0] src_quo;
        logic [DW-1:0] src_dvs;
        logic [SW-1:0] src_side;
        logic          src_valid;
        logic [DW:0]   trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign src_rem   = rem_in;
            assign src_low   = low_in;
            assign src_quo   = '0;
            assign src_dvs   = dvs_in;
            assign src_side  = side_in;
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src_rem   = rem_reg[i-1];
            assign src_low   = low_reg[i-1];
            assign src_quo   = quo_reg[i-1];
            assign src_dvs   = dvs_reg[i-1];
            assign src_side  = side_reg[i-1];
            assign src_valid = valid_reg[i-1];
        end

        // shift in one dividend bit, subtract when it fits
        assign trial = {src_rem, src_low[QW-1]};
        assign ge    = (trial >= {1'b0, src_dvs});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? DW'(trial - {1'b0, src_dvs}) : trial[DW-1:0];
                low_reg[i]  <= {src_low[QW-2:0], 1'b0};
                quo_reg[i]  <= {src_quo[QW-2:0], ge};
                dvs_reg[i]  <= src_dvs;
                side_reg[i] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

FILE: hdl/smith_beckmann_lambda.sv
// ----------------------------------------------------------------------------
// smith_beckmann_lambda: Smith masking lambda for isotropic Beckmann
// Fixed-point pipeline: dot product, tangent via square root, a = 1/(alpha
// tan), rational approximation and a final divide to Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_ready/item carries one normal, one unit
//   direction and a roughness (signed Q1.14 components, unsigned Q2.14
//   alpha). Output channel result_valid/result_ready/result returns the
//   lambda in unsigned Q16.16 and a saturation flag, one result per input
//   transaction, in order.
//   From acceptance to result_valid a transaction passes 3 stages of dot
//   product and clamp, 29 square root stages (one root bit each), 2 stages
//   for the tangent product and normalization, 32 stages for a, 4 stages of
//   polynomial terms and 32 stages for the final quotient (one bit each),
//   plus the output register.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   every stage is a plain register stage, so no unit is shared between transactions.
//   Reset clears all valid bits; the pipeline comes up empty.
//   When the receiver stalls a held result, the whole pipeline freezes and
//   item_ready drops in the same cycle; nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
module smith_beckmann_lambda (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sbl_pkg::sbl_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output sbl_pkg::sbl_result_t result
);

    import sbl_pkg::*;

    localparam int PW = 2 * SBL_COMP_W;
    localparam int SH = PW - 32;
    localparam int EW = (PW > 32) ? PW : 32;

    logic        en;
    logic        result_valid_reg;
    sbl_result_t result_reg;

    // pipeline advances whenever the output register can take a result
    assign en         = !result_valid_reg || result_ready;
    assign item_ready = en;

    // ---------------------------------------------------------------- S1
    logic signed [SBL_COMP_W-1:0] comp_n [3];
    logic signed [SBL_COMP_W-1:0] comp_d [3];
    logic signed [31:0]           term_w [3];

    assign comp_n[0] = item.normal_x;
    assign comp_n[1] = item.normal_y;
    assign comp_n[2] = item.normal_z;
    assign comp_d[0] = item.dir_x;
    assign comp_d[1] = item.dir_y;
    assign comp_d[2] = item.dir_z;

    genvar k;
    for (k = 0; k < 3; k++)
    begin : g_prod
        logic signed [PW-1:0] prod;
        logic [PW-1:0]        mag;
        logic [EW-1:0]        mag_ext;
        logic [EW-1:0]        aligned;
        logic [30:0]          q28_mag;

        // Q.28 magnitude, truncated toward zero
        assign prod    = comp_n[k] * comp_d[k];
        assign mag     = prod[PW-1] ? PW'(-prod) : PW'(prod);
        assign mag_ext = EW'(mag);
        if (SH >= 0)
        begin : g_rsh
            assign aligned = mag_ext >> SH;
        end
        else
        begin : g_lsh
            assign aligned = mag_ext << (-SH);
        end
        assign q28_mag   = aligned[30:0];
        assign term_w[k] = prod[PW-1] ? -$signed({1'b0, q28_mag}) : $signed({1'b0, q28_mag});
    end

    logic signed [31:0]   p0_reg, p1_reg, p2_reg;
    logic [SBL_ROUGH_W-1:0] rough1_reg;
    logic                 v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg     <= term_w[0];
            p1_reg     <= term_w[1];
            p2_reg     <= term_w[2];
            rough1_reg <= (item.roughness < SBL_MIN_ROUGH) ? SBL_MIN_ROUGH : item.roughness;
        end
    end

    // ---------------------------------------------------------------- S2
    logic signed [33:0] dot;
    logic [33:0]        dot_abs;
    logic [28:0]        c_next;

    // |dot| clamped to 1.0
    assign dot     = 34'(p0_reg) + 34'(p1_reg) + 34'(p2_reg);
    assign dot_abs = dot[33] ? 34'(-dot) : 34'(dot);
    assign c_next  = (dot_abs > 34'(1 << 28)) ? 29'(1 << 28) : dot_abs[28:0];

    logic [28:0]            c2_reg;
    logic [SBL_ROUGH_W-1:0] rough2_reg;
    logic                   v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg     <= c_next;
            rough2_reg <= rough1_reg;
        end
    end

    // ---------------------------------------------------------------- S3
    logic [57:0] csq;

    // 1 - c^2 in Q.56
    assign csq = 58'(c2_reg) * 58'(c2_reg);

    logic [57:0]            x3_reg;
    logic [28:0]            c3_reg;
    logic [SBL_ROUGH_W-1:0] rough3_reg;
    logic                   v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x3_reg     <= 58'(58'd1 << 56) - csq;
            c3_reg     <= c2_reg;
            rough3_reg <= rough2_reg;
        end
    end

    // ---------------------------------------------------------------- sqrt
    logic [28:0]            s_w;
    logic [28:0]            c_sq;
    logic [SBL_ROUGH_W-1:0] rough_sq;
    logic                   v_sq;

    sbl_sqrt_pipe #(
        .NR (29),
        .SW (29 + SBL_ROUGH_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .x_in      (x3_reg),
        .side_in   ({c3_reg, rough3_reg}),
        .out_valid (v_sq),
        .root      (s_w),
        .side_out  ({c_sq, rough_sq})
    );

    // ---------------------------------------------------------------- S4
    logic [44:0] t4_reg;
    logic [28:0] c4_reg;
    logic        v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v_sq;
    end

    // T = s * alpha in Q.42
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_reg <= 45'(s_w) * 45'(rough_sq);
            c4_reg <= c_sq;
        end
    end

    // ---------------------------------------------------------------- S5
    logic [42:0] big_c;
    logic [47:0] c_times5;
    logic [47:0] t_times8;
    logic        calc;
    logic [3:0]  nshift;
    logic [44:0] t_norm;
    logic [42:0] c_norm;

    assign big_c    = {c4_reg, 14'b0};
    assign c_times5 = 48'({big_c, 2'b00}) + 48'(big_c);
    assign t_times8 = {t4_reg, 3'b000};
    assign calc     = (c_times5 < t_times8);

    // shift that brings T below 2^32
    always_comb
    begin
        nshift = '0;
        for (int j = 1; j <= 13; j++)
        begin
            if (t4_reg[31+j])
                nshift = 4'(j);
        end
    end

    assign t_norm = t4_reg >> nshift;
    assign c_norm = big_c >> nshift;

    logic [31:0] tn5_reg;
    logic [42:0] cn5_reg;
    logic        calc5_reg;
    logic        v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tn5_reg   <= t_norm[31:0];
            cn5_reg   <= c_norm;
            calc5_reg <= calc;
        end
    end

    // ---------------------------------------------------------------- A = C*2^30/T
    logic [31:0] a_w;
    logic        calc_d1;
    logic        v_d1;

    sbl_div_pipe #(
        .DW (32),
        .QW (32),
        .SW (1)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .rem_in    (cn5_reg[33:2]),
        .low_in    ({cn5_reg[1:0], 30'b0}),
        .dvs_in    (tn5_reg),
        .side_in   (calc5_reg),
        .out_valid (v_d1),
        .quo       (a_w),
        .side_out  (calc_d1)
    );

    // ---------------------------------------------------------------- S6
    logic [63:0] a_sq;

    assign a_sq = 64'(a_w) * 64'(a_w);

    logic [31:0] a6_reg;
    logic [33:0] a2_6_reg;
    logic        calc6_reg;
    logic        azero6_reg;
    logic        v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v_d1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a6_reg     <= a_w;
            a2_6_reg   <= a_sq[63:30];
            calc6_reg  <= calc_d1;
            azero6_reg <= (a_w == '0);
        end
    end

    // ---------------------------------------------------------------- S7
    logic [48:0] m1_reg;
    logic [48:0] m2_reg;
    logic [49:0] d1_reg;
    logic [51:0] d2_reg;
    logic        calc7_reg;
    logic        azero7_reg;
    logic        v7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    // polynomial terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg     <= 49'(SBL_K_LIN) * 49'(a6_reg);
            m2_reg     <= 49'(SBL_K_QUAD) * 49'(a2_6_reg);
            d1_reg     <= 50'(SBL_K_DLIN) * 50'(a6_reg);
            d2_reg     <= 52'(SBL_K_DQUAD) * 52'(a2_6_reg);
            calc7_reg  <= calc6_reg;
            azero7_reg <= azero6_reg;
        end
    end

    // ---------------------------------------------------------------- S8
    logic [53:0] num8_reg;
    logic [52:0] den8_reg;
    logic        calc8_reg;
    logic        azero8_reg;
    logic        v8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= v7_reg;
    end

    // numerator (two's complement) and denominator, Q.46
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num8_reg   <= 54'(54'd1 << 46) - 54'(m1_reg) + 54'(m2_reg);
            den8_reg   <= 53'(d1_reg) + 53'(d2_reg);
            calc8_reg  <= calc7_reg;
            azero8_reg <= azero7_reg;
        end
    end

    // ---------------------------------------------------------------- S9
    logic     num_pos;
    logic     quo_ovf;
    sbl_sel_t sel_next;

    assign num_pos = !num8_reg[53] && (num8_reg != '0);
    // quotient reaches 2^32 exactly when num >= den * 2^16
    assign quo_ovf = ({16'b0, num8_reg} >= {1'b0, den8_reg, 16'b0});

    always_comb
    begin
        sel_next.force_max  = calc8_reg && (azero8_reg || (num_pos && quo_ovf));
        sel_next.force_zero = !calc8_reg || (!azero8_reg && !num_pos);
    end

    logic [50:0] rem9_reg;
    logic [31:0] low9_reg;
    logic [50:0] dvs9_reg;
    sbl_sel_t    sel9_reg;
    logic        v9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else if (en)
            v9_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem9_reg <= 51'(num8_reg[46:16]);
            low9_reg <= {num8_reg[15:0], 16'b0};
            dvs9_reg <= den8_reg[50:0];
            sel9_reg <= sel_next;
        end
    end

    // ---------------------------------------------------------------- lambda = num*2^16/den
    logic [31:0] q_w;
    sbl_sel_t    sel_d2;
    logic        v_d2;

    sbl_div_pipe #(
        .DW (51),
        .QW (32),
        .SW ($bits(sbl_sel_t))
    ) u_div_l (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v9_reg),
        .rem_in    (rem9_reg),
        .low_in    (low9_reg),
        .dvs_in    (dvs9_reg),
        .side_in   (sel9_reg),
        .out_valid (v_d2),
        .quo       (q_w),
        .side_out  (sel_d2)
    );

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= v_d2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sel_d2.force_max)
                result_reg.lambda_value <= '1;
            else if (sel_d2.force_zero)
                result_reg.lambda_value <= '0;
            else
                result_reg.lambda_value <= q_w;
            result_reg.saturated <= sel_d2.force_max;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------- checks
    a_sat_is_max : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.saturated || (result.lambda_value == '1)))
        else $error("saturated result is not at full scale");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !item_ready)
        else $error("input accepted while the output is stalled");

    a_freeze_holds_front : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg))
        else $error("front stage moved during a stall");

    a_sel_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg |-> !(sel9_reg.force_max && sel9_reg.force_zero))
        else $error("both result overrides set");

endmodule

FILE: bench/smith_beckmann_lambda_test.sv
// ----------------------------------------------------------------------------
// smith_beckmann_lambda_test: self-checking bench for the lambda pipeline
// Drives normals, directions and roughness values through the valid/ready
// input, predicts each lambda in fixed point and compares results in order,
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module smith_beckmann_lambda_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbl_pkg::*;

    localparam int LATENCY = 103;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    sbl_item_t   item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    sbl_result_t result;

    sbl_result_t lambda_queue[$];
    int          fail_count = 0;
    int          burst_left = 0;

    smith_beckmann_lambda u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Bitwise integer square root
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Expected lambda for one transaction
    function automatic sbl_result_t lambda_predict(input sbl_item_t it);
        sbl_result_t      res;
        longint signed    dot;
        logic [63:0]      cmag, sroot, cq, tq, rgh, aq, a2, den, quo;
        longint signed    num;
        dot = longint'(it.normal_x) * longint'(it.dir_x)
            + longint'(it.normal_y) * longint'(it.dir_y)
            + longint'(it.normal_z) * longint'(it.dir_z);
        rgh = (it.roughness < SBL_MIN_ROUGH) ? 64'(SBL_MIN_ROUGH) : 64'(it.roughness);
        cmag = (dot < 0) ? 64'(-dot) : 64'(dot);
        if (cmag > (64'd1 << 28)) cmag = 64'd1 << 28;
        sroot = root_floor((64'd1 << 56) - cmag * cmag);
        cq = cmag << 14;
        tq = sroot * rgh;
        res = '0;
        if (5 * cq < 8 * tq)
        begin
            while (tq >= (64'd1 << 32))
            begin
                tq = tq >> 1;
                cq = cq >> 1;
            end
            aq = (cq << 30) / tq;
            if (aq == 0)
            begin
                res.lambda_value = '1;
                res.saturated = 1'b1;
            end
            else
            begin
                a2 = (aq * aq) >> 30;
                num = (longint'(1) << 46) - longint'(SBL_K_LIN) * longint'(aq)
                    + longint'(SBL_K_QUAD) * longint'(a2);
                den = 64'(SBL_K_DLIN) * aq + 64'(SBL_K_DQUAD) * a2;
                if (num > 0)
                begin
                    quo = (64'(num) << 16) / den;
                    if (quo > 64'hFFFF_FFFF)
                    begin
                        res.lambda_value = '1;
                        res.saturated = 1'b1;
                    end
                    else
                        res.lambda_value = quo[31:0];
                end
            end
        end
        return res;
    endfunction

    // Send one transaction; bursts of random length with random gaps
    task automatic send_item(input sbl_item_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= it;
        lambda_queue.push_back(lambda_predict(it));
        do @(posedge clk); while (!item_ready);
    endtask

    function automatic logic signed [15:0] rand_comp();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic sbl_item_t pack_item(input int nx, ny, nz, dx, dy, dz, input int rg);
        sbl_item_t it;
        it.normal_x = 16'(nx); it.normal_y = 16'(ny); it.normal_z = 16'(nz);
        it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
        it.roughness = 16'(rg);
        return it;
    endfunction

    // Receiver stall pattern: alternating ready and stall stretches
    initial
    begin
        int len;
        @(posedge rst_n);
        forever
        begin
            len = $urandom_range(1, 40);
            result_ready <= 1'b1;
            repeat (len) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        sbl_result_t exp_res;
        if (rst_n && result_valid && result_ready)
        begin
            if (lambda_queue.size() == 0)
            begin
                $error("unexpected result %h", result);
                fail_count++;
            end
            else
            begin
                exp_res = lambda_queue.pop_front();
                if (result.lambda_value !== exp_res.lambda_value)
                begin
                    $error("lambda_value exp %h got %h",
                           exp_res.lambda_value, result.lambda_value);
                    fail_count++;
                end
                if (result.saturated !== exp_res.saturated)
                begin
                    $error("saturated exp %b got %b", exp_res.saturated, result.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Directed corners: extremes, parallel, grazing, near 1.6, roughness floor
    task automatic test_corners();
        send_item(pack_item(0, 0, 16384, 0, 0, 16384, 16384));
        send_item(pack_item(0, 0, 16384, 16384, 0, 0, 16384));
        send_item(pack_item(0, 0, -16384, 0, 0, 16384, 65535));
        send_item(pack_item(16384, 16384, 16384, 16384, 16384, 16384, 17));
        send_item(pack_item(-16384, -16384, -16384, 16384, 16384, 16384, 0));
        send_item(pack_item(0, 0, 16384, 11585, 0, 11585, 0));
        send_item(pack_item(0, 0, 16384, 11585, 0, 11585, 5));
        send_item(pack_item(0, 0, 16384, 11585, 0, 11585, 65535));
        send_item(pack_item(0, 0, 16384, 16383, 0, 181, 16384));
        send_item(pack_item(0, 0, 16384, 16383, 0, 1, 65535));
        send_item(pack_item(0, 0, 16384, 16383, 0, 1, 17));
        send_item(pack_item(0, 0, 16384, 8192, 0, 14189, 10240));
        send_item(pack_item(0, 0, 16384, 13000, 0, 9970, 10000));
        send_item(pack_item(0, 0, 16384, 12000, 0, 11150, 9000));
        send_item(pack_item(-16384, 0, 0, 16384, 0, 0, 32768));
        send_item(pack_item(-1, -1, -1, -1, -1, -1, 65535));
        send_item(pack_item(32767, -32768, 0, 32767, -32768, 0, 1));
        send_item(pack_item(0, 0, 0, 0, 0, 0, 16384));
        send_item(pack_item(0, 16384, 0, 0, 3000, 16100, 200));
    endtask

    // Random unit-ish vectors over the full roughness range
    task automatic test_random(input int count);
        sbl_item_t it;
        real th, ph;
        repeat (count)
        begin
            it.normal_x = rand_comp(); it.normal_y = rand_comp(); it.normal_z = rand_comp();
            if ($urandom_range(0, 9) < 7)
            begin
                th = $urandom_range(0, 10000) * 3.14159265 / 10000.0;
                ph = $urandom_range(0, 10000) * 6.2831853 / 10000.0;
                it.normal_x = 0; it.normal_y = 0; it.normal_z = 16384;
                it.dir_x = 16'($rtoi(16384.0 * $sin(th) * $cos(ph)));
                it.dir_y = 16'($rtoi(16384.0 * $sin(th) * $sin(ph)));
                it.dir_z = 16'($rtoi(16384.0 * $cos(th)));
            end
            else
            begin
                it.dir_x = rand_comp(); it.dir_y = rand_comp(); it.dir_z = rand_comp();
                if ($urandom_range(0, 4) == 0)
                begin
                    it.normal_x = 16'($urandom); it.dir_y = 16'($urandom);
                end
            end
            case ($urandom_range(0, 3))
                0: it.roughness = 16'($urandom_range(0, 64));
                1: it.roughness = 16'($urandom_range(0, 4096));
                default: it.roughness = 16'($urandom);
            endcase
            send_item(it);
        end
    endtask

    initial
    begin
        int guard;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(1030);
        item_valid <= 1'b0;
        guard = 0;
        while (lambda_queue.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0 && lambda_queue.size() == 0)
            $display("** smith_beckmann_lambda: PASSED **");
        else
            $display("** smith_beckmann_lambda: FAILED **");
        $finish;
    end

    // Run limit
    initial
    begin
        #2ms;
        $display("** smith_beckmann_lambda: FAILED **");
        $finish;
    end

endmodule
